// ===== rtl/audio_jitter_buffer_assert.svh =====
// Assertion macros for the audio jitter buffer checker.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef AUDIO_JITTER_BUFFER_ASSERT_SVH
`define AUDIO_JITTER_BUFFER_ASSERT_SVH

// Same-cycle implication.
`define AJB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("audio jitter buffer: assertion failed");

// Next-cycle implication.
`define AJB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("audio jitter buffer: assertion failed");

`endif

// ===== rtl/ajb_pkg.sv =====
// Shared types, constants and functions of the audio jitter buffer.
// No dependencies; the files that use it refer to it by scoped names.
package ajb_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEPTH_DEF     = 1024;
    localparam int MAX_BLOCK_DEF = 64;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 7;
    localparam int CFG_W    = 11;
    localparam int FILL_W   = 11;
    localparam int GAIN_W   = 16;

    // Reset value of the prefill level register and three times that value.
    localparam logic [CFG_W-1:0] PREFILL_RESET   = 11'd256;
    localparam logic [CFG_W+1:0] PREFILL3_RESET  = 13'd768;

    // Fade ramp constants in unsigned Q0.16.
    localparam logic [7:0]        GAIN_STEP   = 8'd131;
    localparam logic [GAIN_W-1:0] GAIN_THRESH = 16'd65470;
    localparam logic [GAIN_W-1:0] GAIN_MAX    = 16'hFFFF;

    // Input item kinds.
    localparam logic KIND_PUSH   = 1'b0;
    localparam logic KIND_RENDER = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [LEN_W-1:0]           block_len;
    } ajb_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       last;
        logic                       accepted;
        logic [FILL_W-1:0]          fill_level;
        logic                       playing;
    } ajb_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_EMIT
    } ajb_state_t;

    // Where the sample of a result comes from.
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_RAW,
        SRC_SCALED
    } ajb_src_t;

    // One result as issued by the controller to the output stage.
    typedef struct packed {
        logic              valid;
        ajb_src_t          src;
        logic [GAIN_W-1:0] gain;
        logic              last;
        logic              accepted;
        logic [FILL_W-1:0] fill;
        logic              playing;
    } ajb_issue_t;

    // Raise the gain by ceil((1 - gain) * 0.002), saturating at full scale.
    function automatic logic [GAIN_W-1:0] gain_advance(input logic [GAIN_W-1:0] gain);
        logic [GAIN_W:0]   remain;
        logic [23:0]       prod;
        logic [7:0]        step;
        logic [GAIN_W:0]   sum;
        remain = 17'h10000 - {1'b0, gain};
        prod   = 24'(remain) * 24'(GAIN_STEP) + 24'hFFFF;
        step   = prod[23:16];
        sum    = {1'b0, gain} + 17'(step);
        if (sum[GAIN_W]) begin
            return GAIN_MAX;
        end
        return sum[GAIN_W-1:0];
    endfunction

endpackage

// ===== rtl/ajb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ajb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds when re is low.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ajb_ctrl.sv =====
// Controller of the audio jitter buffer: FIFO pointers, fill, prefill and fade state.
// Depends on ajb_pkg; drives the sample RAM and issues results to ajb_out.
module ajb_ctrl #(
    parameter int DEPTH     = ajb_pkg::DEPTH_DEF,
    parameter int MAX_BLOCK = ajb_pkg::MAX_BLOCK_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ajb_pkg::ajb_in_t                s_data,
    input  logic                            cfg_we,
    input  logic [ajb_pkg::CFG_W-1:0]       cfg_wdata,
    output ajb_pkg::ajb_issue_t             issue,
    input  logic                            issue_ready,
    output logic                            mem_we,
    output logic [$clog2(DEPTH)-1:0]        mem_waddr,
    output logic [ajb_pkg::SAMPLE_W-1:0]    mem_wdata,
    output logic                            mem_re,
    output logic [$clog2(DEPTH)-1:0]        mem_raddr
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int P3W = ajb_pkg::CFG_W + 2;
    // Common width for fill and prefill comparisons.
    localparam int CW = (FW > P3W) ? FW : P3W;
    localparam int LW = $clog2(MAX_BLOCK + 1);
    localparam logic [ajb_pkg::LEN_W-1:0] LEN_MAX  = ajb_pkg::LEN_W'(MAX_BLOCK);
    localparam logic [AW-1:0]             ADDR_TOP = AW'(DEPTH - 1);
    localparam logic [FW-1:0]             FILL_TOP = FW'(DEPTH);

    ajb_pkg::ajb_state_t              state_reg, state_next;
    logic [AW-1:0]                    wr_addr_reg, wr_addr_next;
    logic [AW-1:0]                    rd_addr_reg, rd_addr_next;
    logic [FW-1:0]                    fill_reg, fill_next;
    logic                             done_reg, done_next;
    logic [ajb_pkg::GAIN_W-1:0]       gain_reg, gain_next;
    logic [ajb_pkg::CFG_W-1:0]        prefill_reg, prefill_next;
    logic [P3W-1:0]                   prefill3_reg, prefill3_next;
    logic                             kind_reg, kind_next;
    logic [ajb_pkg::SAMPLE_W-1:0]     sample_reg, sample_next;
    logic [LW-1:0]                    len_reg, len_next;
    logic [LW-1:0]                    cnt_reg, cnt_next;
    logic                             silent_reg, silent_next;
    logic                             fading_reg, fading_next;

    logic [ajb_pkg::LEN_W-1:0]        len_sat;
    logic [AW-1:0]                    wr_inc, rd_inc;
    logic [CW-1:0]                    fill_ext, p_ext, p3_ext;
    logic [CW-1:0]                    fill_up, fill_dn;
    logic                             full;
    logic                             len_last;
    logic [ajb_pkg::GAIN_W-1:0]       gain_up;

    // Helpers: saturated length, wrapped pointer increments, widened compares.
    assign len_sat  = (s_data.block_len > LEN_MAX) ? LEN_MAX : s_data.block_len;
    assign wr_inc   = (wr_addr_reg == ADDR_TOP) ? '0 : wr_addr_reg + 1'b1;
    assign rd_inc   = (rd_addr_reg == ADDR_TOP) ? '0 : rd_addr_reg + 1'b1;
    assign fill_ext = CW'(fill_reg);
    assign p_ext    = CW'(prefill_reg);
    assign p3_ext   = CW'(prefill3_reg);
    assign fill_up  = fill_ext + 1'b1;
    assign fill_dn  = fill_ext - 1'b1;
    assign full     = (fill_reg == FILL_TOP);
    assign len_last = (LW'(cnt_reg + 1'b1) == len_reg);
    assign gain_up  = ajb_pkg::gain_advance(gain_reg);

    // Next state, memory controls and the issued result.
    always_comb begin
        state_next    = state_reg;
        wr_addr_next  = wr_addr_reg;
        rd_addr_next  = rd_addr_reg;
        fill_next     = fill_reg;
        done_next     = done_reg;
        gain_next     = gain_reg;
        prefill_next  = prefill_reg;
        prefill3_next = prefill3_reg;
        kind_next     = kind_reg;
        sample_next   = sample_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        silent_next   = silent_reg;
        fading_next   = fading_reg;

        s_ready   = (state_reg == ajb_pkg::ST_IDLE);
        issue     = '0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_raddr = rd_addr_reg;
        mem_wdata = sample_reg;

        case (state_reg)
            ajb_pkg::ST_IDLE: begin
                if (s_valid) begin
                    kind_next   = s_data.kind;
                    sample_next = s_data.sample_in;
                    len_next    = LW'(len_sat);
                    cnt_next    = '0;
                    if (s_data.kind == ajb_pkg::KIND_PUSH) begin
                        state_next = ajb_pkg::ST_EMIT;
                    end else if (s_data.block_len != '0) begin
                        state_next = ajb_pkg::ST_PREP;
                    end
                end
            end

            // Block start: prefill gate, fade decision and one drift step.
            ajb_pkg::ST_PREP: begin
                if (!done_reg && (fill_ext < p_ext)) begin
                    silent_next = 1'b1;
                end else begin
                    silent_next = 1'b0;
                    if (!done_reg) begin
                        done_next = 1'b1;
                        gain_next = '0;
                    end
                    fading_next = !done_reg || (gain_reg < ajb_pkg::GAIN_THRESH);
                    // Blocks never reach 80 samples, so the drift step drops one sample.
                    if (fill_ext > p3_ext) begin
                        rd_addr_next = rd_inc;
                        fill_next    = FW'(fill_dn);
                    end
                end
                state_next = ajb_pkg::ST_EMIT;
            end

            // One result per transfer into the output stage.
            ajb_pkg::ST_EMIT: begin
                issue.valid   = 1'b1;
                issue.playing = done_reg;
                if (kind_reg == ajb_pkg::KIND_PUSH) begin
                    issue.last = 1'b1;
                    issue.src  = ajb_pkg::SRC_ZERO;
                    if (!full) begin
                        issue.accepted = 1'b1;
                        issue.fill     = fill_up[ajb_pkg::FILL_W-1:0];
                    end else begin
                        issue.fill     = fill_ext[ajb_pkg::FILL_W-1:0];
                    end
                    if (issue_ready) begin
                        if (!full) begin
                            mem_we       = 1'b1;
                            wr_addr_next = wr_inc;
                            fill_next    = FW'(fill_up);
                        end
                        state_next = ajb_pkg::ST_IDLE;
                    end
                end else begin
                    issue.last = len_last;
                    if (!silent_reg && (fill_reg != '0)) begin
                        issue.src  = fading_reg ? ajb_pkg::SRC_SCALED : ajb_pkg::SRC_RAW;
                        issue.gain = fading_reg ? gain_up : gain_reg;
                        issue.fill = fill_dn[ajb_pkg::FILL_W-1:0];
                        if (issue_ready) begin
                            mem_re       = 1'b1;
                            rd_addr_next = rd_inc;
                            fill_next    = FW'(fill_dn);
                            if (fading_reg) begin
                                gain_next = gain_up;
                            end
                        end
                    end else begin
                        issue.src  = ajb_pkg::SRC_ZERO;
                        issue.fill = fill_ext[ajb_pkg::FILL_W-1:0];
                    end
                    if (issue_ready) begin
                        cnt_next = LW'(cnt_reg + 1'b1);
                        if (len_last) begin
                            state_next = ajb_pkg::ST_IDLE;
                        end
                    end
                end
            end

            default: begin
                state_next = ajb_pkg::ST_IDLE;
            end
        endcase

        // Configuration write; three times the level is kept for the drift test.
        if (cfg_we) begin
            prefill_next  = cfg_wdata;
            prefill3_next = P3W'(cfg_wdata) + P3W'({cfg_wdata, 1'b0});
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ajb_pkg::ST_IDLE;
            wr_addr_reg  <= '0;
            rd_addr_reg  <= '0;
            fill_reg     <= '0;
            done_reg     <= 1'b0;
            gain_reg     <= '0;
            prefill_reg  <= ajb_pkg::PREFILL_RESET;
            prefill3_reg <= ajb_pkg::PREFILL3_RESET;
            kind_reg     <= ajb_pkg::KIND_PUSH;
            len_reg      <= '0;
            cnt_reg      <= '0;
            silent_reg   <= 1'b0;
            fading_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wr_addr_reg  <= wr_addr_next;
            rd_addr_reg  <= rd_addr_next;
            fill_reg     <= fill_next;
            done_reg     <= done_next;
            gain_reg     <= gain_next;
            prefill_reg  <= prefill_next;
            prefill3_reg <= prefill3_next;
            kind_reg     <= kind_next;
            len_reg      <= len_next;
            cnt_reg      <= cnt_next;
            silent_reg   <= silent_next;
            fading_reg   <= fading_next;
        end
    end

    // The pushed sample needs no reset.
    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
    end

endmodule

// ===== rtl/ajb_out.sv =====
// Output stage of the audio jitter buffer: RAM read stage, fade scaling, output register.
// Depends on ajb_pkg; takes issued results from ajb_ctrl and read data from ajb_ram.
module ajb_out (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ajb_pkg::ajb_issue_t          issue,
    output logic                         issue_ready,
    input  logic [ajb_pkg::SAMPLE_W-1:0] rd_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output ajb_pkg::ajb_out_t            m_data
);

    logic                        s1_valid_reg, s1_valid_next;
    ajb_pkg::ajb_issue_t         s1_info_reg;
    logic                        m_valid_reg, m_valid_next;
    ajb_pkg::ajb_out_t           m_data_reg, m_data_next;
    logic                        s1_adv;
    logic                        s1_load;
    logic signed [16:0]          gain_s;
    logic signed [33:0]          prod;
    logic signed [33:0]          rounded;

    // Stage one moves on when the output register is free or being emptied.
    assign s1_adv      = s1_valid_reg && (!m_valid_reg || m_ready);
    assign issue_ready = !s1_valid_reg || s1_adv;
    assign s1_load     = issue.valid && issue_ready;

    // Fade scaling with round half up; the arithmetic shift floors.
    assign gain_s  = signed'({1'b0, s1_info_reg.gain});
    assign prod    = 34'(signed'(rd_data)) * 34'(gain_s);
    assign rounded = prod + 34'sd32768;

    // Next values of stage one and of the output register.
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s1_load) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        m_data_next            = m_data_reg;
        m_data_next.last       = s1_info_reg.last;
        m_data_next.accepted   = s1_info_reg.accepted;
        m_data_next.fill_level = s1_info_reg.fill;
        m_data_next.playing    = s1_info_reg.playing;
        case (s1_info_reg.src)
            ajb_pkg::SRC_RAW:    m_data_next.sample_out = signed'(rd_data);
            ajb_pkg::SRC_SCALED: m_data_next.sample_out = rounded[31:16];
            default:             m_data_next.sample_out = '0;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_info_reg <= issue;
        end
        if (s1_adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/audio_jitter_buffer.sv =====
// Audio jitter buffer top level: sample FIFO in RAM with a playback front end.
// Depends on ajb_pkg, ajb_ram, ajb_ctrl and ajb_out.
//
// Usage: the s_ channel carries push and render items, the m_ channel carries
// results, both with valid/ready transfers. A push stores one sample and gives
// one result (accepted is 0 if the FIFO was full). A render gives block_len
// results (saturated to MAX_BLOCK, none for zero): silence until the prefill
// level has been reached once, then FIFO samples with zero-fill on underrun,
// faded in while the ramp is below 0.999 at block start.
// Flow: an item is handled by the controller, whose results pass through the read
// stage to the output register; a render first takes a block-start state (ST_PREP)
// in the controller. Results are issued one per cycle while the output stage takes
// them, with the single RAM read port setting the pace of a render.
// A stalled receiver holds results in the read stage and the output register;
// the controller then pauses, and s_ready stays low until an item's last result
// has left the controller. prefill_level is written through cfg_we/cfg_wdata.
// Reset empties the FIFO, clears playback state and sets the prefill level to
// 256; sample memory contents are left as they are and need no clearing pass.
module audio_jitter_buffer #(
    parameter int DEPTH     = ajb_pkg::DEPTH_DEF,
    parameter int MAX_BLOCK = ajb_pkg::MAX_BLOCK_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  ajb_pkg::ajb_in_t          s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output ajb_pkg::ajb_out_t         m_data,
    input  logic                      cfg_we,
    input  logic [ajb_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(DEPTH);

    ajb_pkg::ajb_issue_t          issue;
    logic                         issue_ready;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [ajb_pkg::SAMPLE_W-1:0] mem_wdata;
    logic                         mem_re;
    logic [AW-1:0]                mem_raddr;
    logic [ajb_pkg::SAMPLE_W-1:0] mem_rdata;

    // Pointer, fill and playback control.
    ajb_ctrl #(
        .DEPTH     (DEPTH),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .issue       (issue),
        .issue_ready (issue_ready),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr)
    );

    // Sample storage.
    ajb_ram #(
        .WIDTH (ajb_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Read stage, fade scaling and output register.
    ajb_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .issue       (issue),
        .issue_ready (issue_ready),
        .rd_data     (mem_rdata),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ===== rtl/ajb_checker.sv =====
// Port-level checks for the audio jitter buffer, bound to the top level.
// Depends on ajb_pkg and the macros in audio_jitter_buffer_assert.svh.
`include "audio_jitter_buffer_assert.svh"

module ajb_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input ajb_pkg::ajb_out_t m_data
);

    // A result that is not taken stays unchanged.
    `AJB_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // Only push results report a stored sample, and they carry no audio.
    `AJB_ASSERT_IMP(a_push_result, m_valid && m_data.accepted, m_data.last && (m_data.sample_out == 16'sd0))

    // Before playback starts every result is silent.
    `AJB_ASSERT_IMP(a_silence, m_valid && !m_data.playing, m_data.sample_out == 16'sd0)

    // Once playback has started it never stops until reset.
    `AJB_ASSERT_NXT(a_playing_sticks, m_valid && m_ready && m_data.playing, !m_valid || m_data.playing)

endmodule

bind audio_jitter_buffer ajb_checker u_ajb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
